// File: src/dscmp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dice sum counter.
// Holds the modulus, the Barrett reduction factor and the multiply-accumulate tag.
// Depends on nothing.
package dscmp_pkg;

	localparam int unsigned VAL_W = 30;

	typedef logic [VAL_W-1:0] residue_t;

	localparam residue_t PRIME = 30'd1000000007;
	localparam logic [31:0] PRIME_X1 = 32'd1000000007;
	localparam logic [31:0] PRIME_X2 = 32'd2000000014;
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

	typedef struct packed {
		logic first;
		logic last;
		logic ident;
		logic a_unit;
		logic b_unit;
		logic use_comp;
		logic comp_one;
	} mac_tag_t;

endpackage

// File: src/dscmp_matmem.sv
`timescale 1ns / 1ps
// Two-bank matrix store with one write port and two registered read ports.
// Depends on dscmp_pkg for the entry type.
module dscmp_matmem #(
	parameter int AW = 7
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  dscmp_pkg::residue_t wr_data,
	input  logic [AW-1:0]       rd_addr_a,
	input  logic [AW-1:0]       rd_addr_b,
	output dscmp_pkg::residue_t rd_data_a,
	output dscmp_pkg::residue_t rd_data_b
);

	dscmp_pkg::residue_t mem [2**AW];
	dscmp_pkg::residue_t rd_a_q;
	dscmp_pkg::residue_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// File: src/dscmp_modmac.sv
`timescale 1ns / 1ps
// Pipelined modular multiply-accumulate: product, Barrett reduction, accumulation.
// Writes each finished matrix entry back to the store. Depends on dscmp_pkg.
module dscmp_modmac #(
	parameter int AW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                iss_valid,
	input  dscmp_pkg::mac_tag_t iss_tag,
	input  logic [AW-1:0]       iss_waddr,
	input  dscmp_pkg::residue_t rd_data_a,
	input  dscmp_pkg::residue_t rd_data_b,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output dscmp_pkg::residue_t wr_data,
	output logic                busy
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, wr_q;
	dscmp_pkg::mac_tag_t tag_s1;
	logic first_s2, first_s3, first_s4, first_s5;
	logic last_s2, last_s3, last_s4, last_s5;
	logic [AW-1:0] waddr_s1, waddr_s2, waddr_s3, waddr_s4, waddr_s5, waddr_q;
	logic [59:0] prod_s2;
	logic [61:0] q2_s3;
	logic [31:0] xl_s3, xl_s4, qp_s4;
	dscmp_pkg::residue_t r_s5, acc_q;

	dscmp_pkg::residue_t a_val, b_val, r_c, sum_c;
	logic [59:0] prod_c;
	logic [61:0] q2_c;
	logic [60:0] qp_full;
	logic [31:0] diff_c;
	logic [30:0] sum_w;

	always_comb begin
		a_val = tag_s1.ident ? dscmp_pkg::residue_t'(tag_s1.a_unit) : rd_data_a;
		if (tag_s1.use_comp) begin
			b_val = dscmp_pkg::residue_t'(tag_s1.comp_one);
		end else if (tag_s1.ident) begin
			b_val = dscmp_pkg::residue_t'(tag_s1.b_unit);
		end else begin
			b_val = rd_data_b;
		end
		prod_c = a_val * b_val;
		q2_c = prod_s2[59:29] * dscmp_pkg::BARRETT_MU;
		qp_full = q2_s3[61:31] * dscmp_pkg::PRIME;
		diff_c = xl_s4 - qp_s4;
		if (diff_c >= dscmp_pkg::PRIME_X2) begin
			r_c = dscmp_pkg::residue_t'(diff_c - dscmp_pkg::PRIME_X2);
		end else if (diff_c >= dscmp_pkg::PRIME_X1) begin
			r_c = dscmp_pkg::residue_t'(diff_c - dscmp_pkg::PRIME_X1);
		end else begin
			r_c = dscmp_pkg::residue_t'(diff_c);
		end
		sum_w = {1'b0, (first_s5 ? '0 : acc_q)} + {1'b0, r_s5};
		if (sum_w >= {1'b0, dscmp_pkg::PRIME}) begin
			sum_c = dscmp_pkg::residue_t'(sum_w - {1'b0, dscmp_pkg::PRIME});
		end else begin
			sum_c = sum_w[29:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			v_s1 <= iss_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			wr_q <= v_s5 && last_s5;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= iss_tag;
		waddr_s1 <= iss_waddr;
		prod_s2 <= prod_c;
		first_s2 <= tag_s1.first;
		last_s2 <= tag_s1.last;
		waddr_s2 <= waddr_s1;
		q2_s3 <= q2_c;
		xl_s3 <= prod_s2[31:0];
		first_s3 <= first_s2;
		last_s3 <= last_s2;
		waddr_s3 <= waddr_s2;
		qp_s4 <= qp_full[31:0];
		xl_s4 <= xl_s3;
		first_s4 <= first_s3;
		last_s4 <= last_s3;
		waddr_s4 <= waddr_s3;
		r_s5 <= r_c;
		first_s5 <= first_s4;
		last_s5 <= last_s4;
		waddr_s5 <= waddr_s4;
		if (v_s5) begin
			acc_q <= sum_c;
		end
		waddr_q <= waddr_s5;
	end

	assign wr_en = wr_q;
	assign wr_addr = waddr_q;
	assign wr_data = acc_q;
	assign busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | wr_q;

endmodule

// File: src/dscmp_seq.sv
`timescale 1ns / 1ps
// Sequencer for square-and-multiply over the exponent bits and for entry indexing.
// Holds the handshake and the result register. Depends on dscmp_pkg.
module dscmp_seq #(
	parameter int ORDER = 6,
	parameter int EXP_BITS = 60,
	localparam int IW = $clog2(ORDER),
	localparam int AW = 2 * IW + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [59:0]         target_sum,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [29:0]         way_count,
	output logic [AW-1:0]       rd_addr_a,
	output logic [AW-1:0]       rd_addr_b,
	input  dscmp_pkg::residue_t rd_data_a,
	output logic                iss_valid,
	output dscmp_pkg::mac_tag_t iss_tag,
	output logic [AW-1:0]       iss_waddr,
	input  logic                mac_busy
);

	localparam int CW = $clog2(EXP_BITS);
	localparam logic [IW-1:0] LAST_IDX = IW'(ORDER - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_RES_RD,
		S_RES_CAP
	} state_t;

	state_t state_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [CW-1:0] bit_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic cur_q, ident_q, mulph_q, rsp_valid_q;
	logic [29:0] way_count_q;
	logic rsp_free;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		rd_addr_b = {cur_q, j_q, k_q};
		if (state_q == S_RES_RD || state_q == S_RES_CAP) begin
			rd_addr_a = {cur_q, LAST_IDX, LAST_IDX};
		end else begin
			rd_addr_a = {cur_q, i_q, j_q};
		end
		iss_valid = (state_q == S_RUN);
		iss_waddr = {~cur_q, i_q, k_q};
		iss_tag.first = (j_q == '0);
		iss_tag.last = (j_q == LAST_IDX);
		iss_tag.ident = ident_q;
		iss_tag.a_unit = (i_q == j_q);
		iss_tag.b_unit = (j_q == k_q);
		iss_tag.use_comp = mulph_q;
		iss_tag.comp_one = ({1'b0, k_q} == ({1'b0, j_q} + (IW + 1)'(1))) || (j_q == LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			exp_q <= '0;
			bit_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			cur_q <= 1'b0;
			ident_q <= 1'b1;
			mulph_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			way_count_q <= '0;
		end else begin
			if (state_q == S_RES_CAP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						exp_q <= EXP_BITS'(target_sum);
						bit_q <= CW'(EXP_BITS - 1);
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						cur_q <= 1'b0;
						ident_q <= 1'b1;
						mulph_q <= 1'b0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (j_q != LAST_IDX) begin
						j_q <= j_q + IW'(1);
					end else begin
						j_q <= '0;
						if (k_q != LAST_IDX) begin
							k_q <= k_q + IW'(1);
						end else begin
							k_q <= '0;
							if (i_q != LAST_IDX) begin
								i_q <= i_q + IW'(1);
							end else begin
								i_q <= '0;
								state_q <= S_DRAIN;
							end
						end
					end
				end
				S_DRAIN: begin
					if (!mac_busy) begin
						cur_q <= ~cur_q;
						ident_q <= 1'b0;
						if (!mulph_q && exp_q[EXP_BITS-1]) begin
							mulph_q <= 1'b1;
							state_q <= S_RUN;
						end else begin
							mulph_q <= 1'b0;
							if (bit_q == '0) begin
								state_q <= S_RES_RD;
							end else begin
								bit_q <= bit_q - CW'(1);
								exp_q <= {exp_q[EXP_BITS-2:0], 1'b0};
								state_q <= S_RUN;
							end
						end
					end
				end
				S_RES_RD: begin
					state_q <= S_RES_CAP;
				end
				S_RES_CAP: begin
					if (rsp_free) begin
						way_count_q <= ident_q ? 30'd1 : rd_data_a;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign way_count = way_count_q;

endmodule

// File: src/dice_sum_count_matrix_power_core.sv
`timescale 1ns / 1ps
// Dice sum counter: ways to reach a sum with ordered die throws, modulo 1000000007.
// Depends on dscmp_pkg, dscmp_matmem, dscmp_modmac and dscmp_seq.
//
// The request channel (req_valid, req_stall, target_sum) takes one transaction
// per target sum; the response channel (rsp_valid, rsp_stall, way_count)
// returns exactly one transaction for each request, in order.
// The block raises the ORDER x ORDER companion matrix to the power target_sum
// by square-and-multiply over the low EXP_BITS exponent bits, most significant
// bit first. Matrices live in a two-bank memory; one modular multiply-accumulate
// pipeline handles one term per cycle and writes each finished entry back.
// Each matrix product issues ORDER^3 terms and then lets the pipeline drain
// before the next product reads its result. A request takes (EXP_BITS +
// number of set exponent bits) products. One request is processed at a
// time; req_stall is high until the result enters the output register, so
// a new request can be accepted while rsp_stall holds a result.
// Reset clears all control state; no clearing pass over the memory is needed.
module dice_sum_count_matrix_power_core #(
	parameter int ORDER = 6,
	parameter int EXP_BITS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [59:0] target_sum,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [29:0] way_count
);

	localparam int AW = 2 * $clog2(ORDER) + 1;

	logic [AW-1:0] rd_addr_a, rd_addr_b, iss_waddr, wr_addr;
	dscmp_pkg::residue_t rd_data_a, rd_data_b, wr_data;
	dscmp_pkg::mac_tag_t iss_tag;
	logic iss_valid, wr_en, mac_busy;

	dscmp_seq #(
		.ORDER(ORDER),
		.EXP_BITS(EXP_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.target_sum(target_sum),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.way_count(way_count),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.iss_valid(iss_valid),
		.iss_tag(iss_tag),
		.iss_waddr(iss_waddr),
		.mac_busy(mac_busy)
	);

	dscmp_matmem #(
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	dscmp_modmac #(
		.AW(AW)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.iss_valid(iss_valid),
		.iss_tag(iss_tag),
		.iss_waddr(iss_waddr),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.busy(mac_busy)
	);

endmodule

// File: tb/sv/dice_sum_count_matrix_power_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for dice_sum_count_matrix_power_core.
// Drives target sums through the request channel and checks each way count
// against a matrix-power predictor. Depends on dscmp_pkg and the core.
module dice_sum_count_matrix_power_core_test;

	localparam int FACES = 6;
	localparam int EXP_W = 60;
	localparam longint unsigned CYCLE_LIMIT = 64'd25_000_000;
	localparam int unsigned HOLD_AT = 40;
	localparam int unsigned HOLD_LEN = 70000;
	localparam int unsigned SETTLE_CYCLES = 30000;
	localparam int RANDOM_SUMS = 80;

	typedef struct {
		logic [EXP_W-1:0] sum;
		logic             drain;
	} sum_req_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [EXP_W-1:0]    target_sum = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	dscmp_pkg::residue_t way_count;

	sum_req_t            sum_queue[$];
	dscmp_pkg::residue_t way_fifo[$];
	int unsigned n_accepted = 0;
	int unsigned n_done = 0;
	int unsigned mismatches = 0;
	int unsigned total_sums = 0;
	longint unsigned cycles = 0;

	logic        req_fire;
	logic        results_owed;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned stall_mode = 0;
	int unsigned mode_left = 0;

	dice_sum_count_matrix_power_core #(
		.ORDER(FACES),
		.EXP_BITS(EXP_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.target_sum(target_sum),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.way_count(way_count)
	);

	function automatic dscmp_pkg::residue_t dice_ways(logic [EXP_W-1:0] n);
		longint unsigned acc [FACES][FACES];
		longint unsigned comp [FACES][FACES];
		longint unsigned prod [FACES][FACES];
		longint unsigned modulus;
		longint unsigned s;
		longint unsigned rhs;
		int b;
		int pass;
		int i;
		int j;
		int k;
		modulus = 64'(dscmp_pkg::PRIME);
		for (i = 0; i < FACES; i++) begin
			for (j = 0; j < FACES; j++) begin
				acc[i][j] = (i == j) ? 64'd1 : 64'd0;
				comp[i][j] = (j == i + 1 || i == FACES - 1) ? 64'd1 : 64'd0;
			end
		end
		for (b = EXP_W - 1; b >= 0; b--) begin
			for (pass = 0; pass < 2; pass++) begin
				if (pass == 0 || n[b]) begin
					for (i = 0; i < FACES; i++) begin
						for (k = 0; k < FACES; k++) begin
							s = 0;
							for (j = 0; j < FACES; j++) begin
								rhs = (pass == 0) ? acc[j][k] : comp[j][k];
								s = (s + (acc[i][j] * rhs) % modulus) % modulus;
							end
							prod[i][k] = s;
						end
					end
					acc = prod;
				end
			end
		end
		return dscmp_pkg::residue_t'(acc[FACES-1][FACES-1]);
	endfunction

	task automatic queue_sum(logic [EXP_W-1:0] s, logic drain);
		sum_req_t r;
		r.sum = s;
		r.drain = drain;
		sum_queue.insert(sum_queue.size(), r);
	endtask

	task automatic note_mismatch(string what, dscmp_pkg::residue_t want,
		dscmp_pkg::residue_t got);
		if (mismatches < 10)
			$display("%0t: %s: expected way_count %0d, got %0d", $realtime, what, want, got);
		mismatches++;
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// Request driver: bursts of sums with random gaps; a marked sum waits until the
	// block has returned every outstanding transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			target_sum <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			req_fire = req_valid && !req_stall;
			results_owed = (n_accepted + (req_fire ? 1 : 0)) != n_done;
			if (!req_valid || req_fire) begin
				if (gap_left != 0) begin
					req_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (sum_queue.size() != 0 && !(sum_queue[0].drain && results_owed)) begin
					req_valid <= 1'b1;
					target_sum <= sum_queue[0].sum;
					void'(sum_queue.pop_front());
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 5);
						gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30000)
							: $urandom_range(0, 3);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response stall pattern, with one long hold-off that lets the block back up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
		end else if (!hold_done && n_done == HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(50, 3000);
			end else begin
				mode_left <= mode_left - 1;
			end
			unique case (stall_mode)
				0: begin
					rsp_stall <= 1'b0;
				end
				1: begin
					rsp_stall <= ($urandom_range(0, 1) != 0);
				end
				default: begin
					rsp_stall <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_accepted <= 0;
			n_done <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				way_fifo.insert(way_fifo.size(), dice_ways(target_sum));
				n_accepted <= n_accepted + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				n_done <= n_done + 1;
				if (way_fifo.size() == 0)
					note_mismatch("unexpected transaction", '0, way_count);
				else if (way_count !== way_fifo[0])
					note_mismatch("way_count", way_fifo[0], way_count);
				if (way_fifo.size() != 0)
					void'(way_fifo.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [63:0] r;
		int          pick;
		int          n;
		queue_sum(60'd0, 1'b0);
		queue_sum(60'd1, 1'b0);
		queue_sum(60'd2, 1'b0);
		queue_sum(60'd3, 1'b0);
		queue_sum(60'd5, 1'b0);
		queue_sum(60'd6, 1'b0);
		queue_sum(60'd7, 1'b0);
		queue_sum(60'd8, 1'b0);
		queue_sum(60'd12, 1'b0);
		queue_sum(60'd100, 1'b0);
		queue_sum(60'd1000000, 1'b0);
		queue_sum(60'd1000000006, 1'b0);
		queue_sum(60'd1000000007, 1'b0);
		queue_sum(60'd1 << 30, 1'b0);
		queue_sum(60'd1 << 59, 1'b0);
		queue_sum((60'd1 << 59) - 1, 1'b0);
		queue_sum({60{1'b1}}, 1'b0);
		queue_sum({30{2'b01}}, 1'b0);
		queue_sum({30{2'b10}}, 1'b0);
		queue_sum({EXP_W{1'b1}} ^ 60'd1, 1'b0);
		for (n = 0; n < RANDOM_SUMS; n++) begin
			r = {$urandom, $urandom};
			pick = $urandom_range(0, 19);
			if (pick < 3)
				r = 64'($urandom_range(0, 64));
			else if (pick == 3)
				r = 64'd1 << $urandom_range(0, EXP_W - 1);
			else if (pick == 4)
				r = ~(64'd1 << $urandom_range(0, EXP_W - 1));
			queue_sum(r[EXP_W-1:0], n == 0 || n == RANDOM_SUMS / 2);
		end
		total_sums = sum_queue.size();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (n_accepted != total_sums || n_done != total_sums)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && way_fifo.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
